FILE: design/rs1209_pkg.sv
// ----------------------------------------------------------------------------
// Reed-Solomon (12,9) package
// GF(2^8) arithmetic over x^8+x^4+x^3+x^2+1, generator coefficients and
// request codes shared by the codec.
// ----------------------------------------------------------------------------
package rs1209_pkg;

    localparam int NBytes = 12;
    localparam int KBytes = 9;
    localparam int ByteW = 8;
    localparam int WordW = NBytes * ByteW;
    localparam logic [8:0] GfPoly = 9'h11D;

    // Generator (x+a)(x+a^2)(x+a^3) = x^3 + G2 x^2 + G1 x + G0.
    localparam logic [7:0] G0 = 8'h40;
    localparam logic [7:0] G1 = 8'h38;
    localparam logic [7:0] G2 = 8'h0E;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_DECODE = 1'b1
    } req_t;

    typedef logic [7:0] gf_t;

    function automatic gf_t gf_mul(input gf_t a, input gf_t b);
        logic [8:0] x;
        gf_t        p;
        x = {1'b0, a};
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p = p ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ GfPoly;
            end
        end
        return p;
    endfunction

    // Only used with constant exponents, so it folds away at elaboration.
    function automatic gf_t gf_pow(input int n);
        gf_t v;
        v = 8'h01;
        for (int i = 0; i < 255; i++) begin
            if (i < (n % 255)) begin
                v = gf_mul(v, 8'h02);
            end
        end
        return v;
    endfunction

    // One message byte through the parity divider; state is {r0, r1, r2}.
    function automatic logic [23:0] lfsr_step(input logic [23:0] st, input gf_t b);
        gf_t fb;
        fb = b ^ st[23:16];
        return {st[15:8] ^ gf_mul(fb, G2), st[7:0] ^ gf_mul(fb, G1), gf_mul(fb, G0)};
    endfunction

endpackage

FILE: design/reed_solomon_12_9_codec.sv
// ----------------------------------------------------------------------------
// Reed-Solomon (12,9) codec
// Shortened RS(12,9) over GF(2^8): systematic encode of nine bytes, or decode
// of twelve bytes with correction of a single byte error.
// ----------------------------------------------------------------------------
// The codec takes one item per clock unless the result side stalls, and
// returns its result through a three-stage pipeline: syndromes and the first third of the
// parity divider, then the error check and locator search, then the
// correction and the last third of the divider into the output register.
// Backpressure on the result side holds every stage at once, so the sustained
// rate is one item per cycle whenever m_tready is high.
module reed_solomon_12_9_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // word_high [63:0], word_low [95:64]
    input  logic [0:0]  s_tuser,  // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // code_high [63:0], code_low [95:64]
    output logic [1:0]  m_tuser   // decode_ok [0], corrected_count [1]
);

    localparam int W = rs1209_pkg::WordW;

    logic                  adv;
    logic [W-1:0]          din;

    logic                  s1_valid_reg;
    logic                  s1_type_reg;
    logic [W-1:0]          s1_data_reg;
    rs1209_pkg::gf_t       s1_syn_reg [3];
    rs1209_pkg::gf_t       s1_syn_next [3];
    logic [23:0]           s1_par_reg;
    logic [23:0]           s1_par_next;

    logic                  s2_valid_reg;
    logic                  s2_type_reg;
    logic [W-1:0]          s2_data_reg;
    logic [23:0]           s2_par_reg;
    logic [23:0]           s2_par_next;
    logic                  s2_clean_reg;
    logic                  s2_clean_next;
    logic                  s2_fix_reg;
    logic                  s2_fix_next;
    logic [11:0]           s2_hit_reg;
    logic [11:0]           s2_hit_next;
    rs1209_pkg::gf_t       s2_val_reg;
    rs1209_pkg::gf_t       s2_val_next;

    logic                  out_valid_reg;
    logic [W-1:0]          out_data_reg;
    logic [W-1:0]          out_data_next;
    logic                  out_ok_reg;
    logic                  out_ok_next;
    logic                  out_cnt_reg;
    logic                  out_cnt_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign din      = {s_tdata[63:0], s_tdata[95:64]};

    // Stage 1: syndromes and parity over message bytes 0..2.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            s1_syn_next[j] = '0;
            for (int i = 0; i < rs1209_pkg::NBytes; i++) begin
                s1_syn_next[j] = s1_syn_next[j] ^ rs1209_pkg::gf_mul(
                    din[W-1-8*i -: 8], rs1209_pkg::gf_pow((j + 1) * (11 - i)));
            end
        end
        s1_par_next = '0;
        for (int i = 0; i < 3; i++) begin
            s1_par_next = rs1209_pkg::lfsr_step(s1_par_next, din[W-1-8*i -: 8]);
        end
    end

    // Stage 2: consistency check and error locator search, parity bytes 3..5.
    always_comb begin
        logic mismatch;
        mismatch = rs1209_pkg::gf_mul(s1_syn_reg[1], s1_syn_reg[1])
                   != rs1209_pkg::gf_mul(s1_syn_reg[0], s1_syn_reg[2]);
        s2_clean_next = (s1_syn_reg[0] == '0) && (s1_syn_reg[1] == '0)
                        && (s1_syn_reg[2] == '0);
        s2_val_next = '0;
        for (int e = 0; e < rs1209_pkg::NBytes; e++) begin
            s2_hit_next[e] = rs1209_pkg::gf_mul(s1_syn_reg[0], rs1209_pkg::gf_pow(e))
                             == s1_syn_reg[1];
            if (s2_hit_next[e]) begin
                s2_val_next = s2_val_next | rs1209_pkg::gf_mul(
                    s1_syn_reg[0], rs1209_pkg::gf_pow(255 - e));
            end
        end
        s2_fix_next = !s2_clean_next && (s1_syn_reg[0] != '0) && (s1_syn_reg[1] != '0)
                      && !mismatch && (|s2_hit_next);
        s2_par_next = s1_par_reg;
        for (int i = 3; i < 6; i++) begin
            s2_par_next = rs1209_pkg::lfsr_step(s2_par_next, s1_data_reg[W-1-8*i -: 8]);
        end
    end

    // Stage 3: correction or final parity into the output register.
    always_comb begin
        logic [23:0]  par;
        logic [W-1:0] mask;
        par = s2_par_reg;
        for (int i = 6; i < rs1209_pkg::KBytes; i++) begin
            par = rs1209_pkg::lfsr_step(par, s2_data_reg[W-1-8*i -: 8]);
        end
        for (int e = 0; e < rs1209_pkg::NBytes; e++) begin
            mask[8*e +: 8] = (s2_fix_reg && s2_hit_reg[e]) ? s2_val_reg : 8'h00;
        end
        if (s2_type_reg == rs1209_pkg::REQ_ENCODE) begin
            out_data_next = {s2_data_reg[W-1:24], par};
            out_ok_next   = 1'b1;
            out_cnt_next  = 1'b0;
        end else begin
            out_data_next = s2_data_reg ^ mask;
            out_ok_next   = s2_clean_reg || s2_fix_reg;
            out_cnt_next  = s2_fix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_type_reg  <= s_tuser[0];
            s1_data_reg  <= din;
            s1_syn_reg   <= s1_syn_next;
            s1_par_reg   <= s1_par_next;
            s2_type_reg  <= s1_type_reg;
            s2_data_reg  <= s1_data_reg;
            s2_par_reg   <= s2_par_next;
            s2_clean_reg <= s2_clean_next;
            s2_fix_reg   <= s2_fix_next;
            s2_hit_reg   <= s2_hit_next;
            s2_val_reg   <= s2_val_next;
            out_data_reg <= out_data_next;
            out_ok_reg   <= out_ok_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg[31:0], out_data_reg[W-1:32]};
    assign m_tuser  = {out_cnt_reg, out_ok_reg};

endmodule
